// ===== hdl/swmn_pkg.sv =====
// ============================================================================
// swmn_pkg
// Shared constants, reciprocal table and controller/datapath bundles for the
// sliding window mean normalizer.
// ============================================================================
package swmn_pkg;

    localparam int unsigned FRAME_DIM_DEF   = 8;
    localparam int unsigned WINDOW_MAX_DEF  = 100;
    localparam int unsigned HOLD_FRAMES_DEF = 7;

    localparam int unsigned COEFF_W    = 24;
    localparam int unsigned NORM_W     = 25;
    localparam int unsigned SUM_W      = 40;
    localparam int unsigned MEAN_W     = 32;
    localparam int unsigned FCNT_W     = 32;
    localparam int unsigned RECIP_W    = 25;
    localparam int unsigned RECIP_LEN  = 100;
    localparam int unsigned RECIP_FRAC = 24;
    localparam int unsigned Q_SHIFT    = 4;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LSEEK   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MFLUSH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PUPDATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH  = 3'd5;

    // Q24 reciprocals of 1..100
    localparam logic [RECIP_W-1:0] RECIP_TAB [RECIP_LEN] = '{
        25'd16777216, 25'd8388608, 25'd5592405, 25'd4194304, 25'd3355443,
        25'd2796203, 25'd2396745, 25'd2097152, 25'd1864135, 25'd1677722,
        25'd1525201, 25'd1398101, 25'd1290555, 25'd1198373, 25'd1118481,
        25'd1048576, 25'd986895, 25'd932068, 25'd883011, 25'd838861,
        25'd798915, 25'd762601, 25'd729444, 25'd699051, 25'd671089,
        25'd645278, 25'd621378, 25'd599186, 25'd578525, 25'd559241,
        25'd541201, 25'd524288, 25'd508400, 25'd493448, 25'd479349,
        25'd466034, 25'd453438, 25'd441506, 25'd430185, 25'd419430,
        25'd409200, 25'd399458, 25'd390168, 25'd381300, 25'd372827,
        25'd364722, 25'd356962, 25'd349525, 25'd342392, 25'd335544,
        25'd328965, 25'd322639, 25'd316551, 25'd310689, 25'd305040,
        25'd299593, 25'd294337, 25'd289262, 25'd284360, 25'd279620,
        25'd275036, 25'd270600, 25'd266305, 25'd262144, 25'd258111,
        25'd254200, 25'd250406, 25'd246724, 25'd243148, 25'd239675,
        25'd236299, 25'd233017, 25'd229825, 25'd226719, 25'd223696,
        25'd220753, 25'd217886, 25'd215093, 25'd212370, 25'd209715,
        25'd207126, 25'd204600, 25'd202135, 25'd199729, 25'd197379,
        25'd195084, 25'd192842, 25'd190650, 25'd188508, 25'd186414,
        25'd184365, 25'd182361, 25'd180400, 25'd178481, 25'd176602,
        25'd174763, 25'd172961, 25'd171196, 25'd169467, 25'd167772
    };

    typedef struct packed {
        logic in_data;   // data coefficient taken
        logic fill;      // zero-fill short frame
        logic wprep;     // window pointer update
        logic wrd;       // read new and oldest coefficient
        logic wsum;      // running sum update
        logic mlo;       // low partial product
        logic mhi;       // high partial product
        logic wmean;     // mean write
        logic decide;    // release decision
        logic flush;     // flush command
        logic rld;       // load output register
        logic rel_rd;    // release read address select
        logic dim_clr;
        logic dim_inc;
        logic pop;       // retire oldest held frame
    } t_cmd;

    typedef struct packed {
        logic idx_full;
        logic dim_last;
        logic rel_req;
        logic rel_more;
        logic cnt_zero;
    } t_sts;

endpackage

// ===== hdl/swmn_in_if.sv =====
// ============================================================================
// swmn_in_if
// Input channel: one coefficient or flush command per transaction.
// ============================================================================
interface swmn_in_if;
    import swmn_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic signed [COEFF_W-1:0] coeff_value;
    logic                      frame_end;

    modport source (output valid, command, coeff_value, frame_end, input ready);
    modport sink   (input valid, command, coeff_value, frame_end, output ready);
endinterface

// ===== hdl/swmn_out_if.sv =====
// ============================================================================
// swmn_out_if
// Output channel: one normalized coefficient per transaction.
// ============================================================================
interface swmn_out_if;
    import swmn_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [NORM_W-1:0] norm_value;
    logic                     out_frame_end;
    logic                     run_last;

    modport source (output valid, norm_value, out_frame_end, run_last, input ready);
    modport sink   (input valid, norm_value, out_frame_end, run_last, output ready);
endinterface

// ===== hdl/swmn_ctrl.sv =====
// ============================================================================
// swmn_ctrl
// Sequencer: coefficient intake, window update per dimension, release loop.
// ============================================================================
module swmn_ctrl
    import swmn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_command,
    input  logic i_frame_end,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FILL   = 4'd1;
    localparam logic [3:0] S_WPREP  = 4'd2;
    localparam logic [3:0] S_WRD    = 4'd3;
    localparam logic [3:0] S_WSUM   = 4'd4;
    localparam logic [3:0] S_MLO    = 4'd5;
    localparam logic [3:0] S_MHI    = 4'd6;
    localparam logic [3:0] S_WMEAN  = 4'd7;
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_FLUSH  = 4'd9;
    localparam logic [3:0] S_RCHK   = 4'd10;
    localparam logic [3:0] S_RRD    = 4'd11;
    localparam logic [3:0] S_RLD    = 4'd12;
    localparam logic [3:0] S_ROUT   = 4'd13;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.in_data = !i_command;
                    if (i_command) begin
                        n_state = S_FLUSH;
                    end else if (i_frame_end) begin
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.idx_full) begin
                    n_state = S_WPREP;
                end
            end
            S_WPREP: begin
                o_cmd.wprep   = 1'b1;
                o_cmd.dim_clr = 1'b1;
                n_state       = S_WRD;
            end
            S_WRD: begin
                o_cmd.wrd = 1'b1;
                n_state   = S_WSUM;
            end
            S_WSUM: begin
                o_cmd.wsum = 1'b1;
                n_state    = S_MLO;
            end
            S_MLO: begin
                o_cmd.mlo = 1'b1;
                n_state   = S_MHI;
            end
            S_MHI: begin
                o_cmd.mhi = 1'b1;
                n_state   = S_WMEAN;
            end
            S_WMEAN: begin
                o_cmd.wmean = 1'b1;
                if (i_sts.dim_last) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.dim_inc = 1'b1;
                    n_state       = S_WRD;
                end
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = S_RCHK;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_RCHK;
            end
            S_RCHK: begin
                o_cmd.dim_clr = 1'b1;
                o_cmd.rel_rd  = 1'b1;
                n_state = (i_sts.rel_req && !i_sts.cnt_zero) ? S_RRD : S_IDLE;
            end
            S_RRD: begin
                o_cmd.rel_rd = 1'b1;
                n_state      = S_RLD;
            end
            S_RLD: begin
                o_cmd.rld = 1'b1;
                n_state   = S_ROUT;
            end
            S_ROUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (!i_sts.dim_last) begin
                        o_cmd.dim_inc = 1'b1;
                        n_state       = S_RRD;
                    end else begin
                        o_cmd.pop     = 1'b1;
                        o_cmd.dim_clr = 1'b1;
                        n_state = i_sts.rel_more ? S_RRD : S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/swmn_dp.sv =====
// ============================================================================
// swmn_dp
// Datapath: held-frame and window memories, running sums, shared multiplier,
// release arithmetic and configuration registers.
// ============================================================================
module swmn_dp
    import swmn_pkg::*;
#(
    parameter int unsigned FRAME_DIM   = FRAME_DIM_DEF,
    parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int unsigned HOLD_FRAMES = HOLD_FRAMES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic signed [COEFF_W-1:0] i_coeff,
    output logic signed [NORM_W-1:0]  o_norm,
    output logic                      o_frame_end,
    output logic                      o_run_last
);

    localparam int unsigned HOLD_SLOTS = HOLD_FRAMES + 1;
    localparam int unsigned DW   = (FRAME_DIM > 1) ? $clog2(FRAME_DIM) : 1;
    localparam int unsigned IW   = $clog2(FRAME_DIM + 1);
    localparam int unsigned HSW  = $clog2(HOLD_SLOTS);
    localparam int unsigned HCW  = $clog2(HOLD_SLOTS + 1);
    localparam int unsigned HC1  = HCW + 1;
    localparam int unsigned HAW  = $clog2(HOLD_SLOTS * FRAME_DIM);
    localparam int unsigned HDEP = HOLD_SLOTS * FRAME_DIM;
    localparam int unsigned WSW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned WFW  = $clog2(WINDOW_MAX + 1);
    localparam int unsigned W2W  = $clog2(2 * WINDOW_MAX + 1);
    localparam int unsigned WDEP = WINDOW_MAX * FRAME_DIM;
    localparam int unsigned WAW  = (WDEP > 1) ? $clog2(WDEP) : 1;
    localparam int unsigned CW   = (HCW > 3) ? HCW + 1 : 4;
    localparam int unsigned PLO_W = 45;
    localparam int unsigned PRD_W = 47;
    localparam int unsigned TOT_W = 56;

    // configuration
    logic [6:0] r_cfg_win;
    logic [2:0] r_cfg_smf, r_cfg_ls, r_cfg_mf, r_cfg_pu;
    logic       r_cfg_smooth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_win    <= '0;
            r_cfg_smf    <= '0;
            r_cfg_ls     <= '0;
            r_cfg_mf     <= '0;
            r_cfg_pu     <= '0;
            r_cfg_smooth <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW:  r_cfg_win    <= i_cfg_data;
                CFG_START:   r_cfg_smf    <= i_cfg_data[2:0];
                CFG_LSEEK:   r_cfg_ls     <= i_cfg_data[2:0];
                CFG_MFLUSH:  r_cfg_mf     <= i_cfg_data[2:0];
                CFG_PUPDATE: r_cfg_pu     <= i_cfg_data[2:0];
                CFG_SMOOTH:  r_cfg_smooth <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control and pointer state
    logic [IW-1:0]     r_idx;
    logic [DW-1:0]     r_dim;
    logic [HSW-1:0]    r_hhead;
    logic [HCW-1:0]    r_hcnt;
    logic [FCNT_W-1:0] r_fcnt;
    logic [WFW-1:0]    r_wfill;
    logic [WSW-1:0]    r_whead;
    logic              r_full, r_win_en, r_rel_req, r_rel_all;
    logic [WSW-1:0]    r_old_slot, r_new_slot;
    logic [RECIP_W-1:0] r_recip;
    logic signed [SUM_W-1:0]  r_sum   [FRAME_DIM];
    logic signed [MEAN_W-1:0] r_wmean [FRAME_DIM];
    logic signed [MEAN_W-1:0] r_amean [FRAME_DIM];
    logic [PLO_W-1:0]         r_plo;
    logic signed [PRD_W-1:0]  r_phi;

    logic idx_full, dim_last, rel_more;
    assign idx_full = (r_idx == IW'(FRAME_DIM));
    assign dim_last = (r_dim == DW'(FRAME_DIM - 1));
    assign rel_more = r_rel_all && (r_hcnt > HCW'(1));

    assign o_sts.idx_full = idx_full;
    assign o_sts.dim_last = dim_last;
    assign o_sts.rel_req  = r_rel_req;
    assign o_sts.rel_more = rel_more;
    assign o_sts.cnt_zero = (r_hcnt == '0);

    // held ring slots
    logic [HCW:0]   cur_sum;
    logic [HSW-1:0] cur_slot, head_nxt, rd_slot;
    assign cur_sum  = HC1'(r_hhead) + HC1'(r_hcnt);
    assign cur_slot = (cur_sum >= HC1'(HOLD_SLOTS)) ? HSW'(cur_sum - HC1'(HOLD_SLOTS))
                                                    : HSW'(cur_sum);
    assign head_nxt = (r_hhead == HSW'(HOLD_SLOTS - 1)) ? '0 : r_hhead + 1'b1;
    assign rd_slot  = i_cmd.rel_rd ? r_hhead : cur_slot;

    // held-frame memory
    logic signed [COEFF_W-1:0] m_held [HDEP];
    logic signed [COEFF_W-1:0] r_hrd;
    logic                      hwe;
    logic [HAW-1:0]            hwa, hra;
    assign hwe = (i_cmd.in_data || i_cmd.fill) && !idx_full;
    assign hwa = HAW'(cur_slot * FRAME_DIM + r_idx);
    assign hra = HAW'(rd_slot * FRAME_DIM + r_dim);

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            m_held[hwa] <= i_cmd.in_data ? i_coeff : '0;
        end
        r_hrd <= m_held[hra];
    end

    // window memory
    logic signed [COEFF_W-1:0] m_win [WDEP];
    logic signed [COEFF_W-1:0] r_wrd;
    logic [WAW-1:0]            wwa, wra;
    assign wwa = WAW'(r_new_slot * FRAME_DIM + r_dim);
    assign wra = WAW'(r_old_slot * FRAME_DIM + r_dim);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wsum && r_win_en) begin
            m_win[wwa] <= r_hrd;
        end
        if (i_cmd.wrd) begin
            r_wrd <= m_win[wra];
        end
    end

    // window pointer math
    logic [6:0]        win, cum_idx, recip_idx;
    logic              full;
    logic [W2W-1:0]    slot_sum;
    logic [WSW-1:0]    new_slot, whead_nxt;
    logic [FCNT_W-1:0] fc_new;

    assign win      = (r_cfg_win > 7'(WINDOW_MAX)) ? 7'(WINDOW_MAX) : r_cfg_win;
    assign full     = (win != '0) && (8'(r_wfill) >= 8'(win));
    assign slot_sum = W2W'(r_whead) + W2W'(r_wfill);
    assign new_slot = (slot_sum >= W2W'(WINDOW_MAX)) ? WSW'(slot_sum - W2W'(WINDOW_MAX))
                                                     : WSW'(slot_sum);
    assign whead_nxt = (r_whead == WSW'(WINDOW_MAX - 1)) ? '0 : r_whead + 1'b1;
    assign fc_new    = (&r_fcnt) ? r_fcnt : r_fcnt + 1'b1;
    assign cum_idx   = (fc_new > FCNT_W'(RECIP_LEN)) ? 7'(RECIP_LEN) : fc_new[6:0];
    assign recip_idx = full ? win - 1'b1 : cum_idx - 1'b1;

    // sum update and shared multiplier
    logic signed [COEFF_W:0]   vdiff;
    logic signed [SUM_W-1:0]   delta;
    logic signed [20:0]        mul_a;
    logic signed [RECIP_W:0]   mul_b;
    logic signed [PRD_W-1:0]   prod;
    logic [TOT_W-1:0]          tot;

    assign vdiff = 25'(r_hrd) - (r_full ? 25'(r_wrd) : 25'sd0);
    assign delta = SUM_W'(vdiff) <<< Q_SHIFT;
    assign mul_a = i_cmd.mlo ? $signed({1'b0, r_sum[r_dim][19:0]})
                             : $signed({r_sum[r_dim][SUM_W-1], r_sum[r_dim][SUM_W-1:20]});
    assign mul_b = $signed({1'b0, r_recip});
    assign prod  = PRD_W'(mul_a) * PRD_W'(mul_b);
    assign tot   = {r_phi[35:0], 20'b0} + TOT_W'(r_plo);

    // release arithmetic
    logic signed [33:0] ndiff;
    logic signed [29:0] nshr;
    logic signed [NORM_W-1:0] nsat;
    assign ndiff = (34'(r_hrd) <<< Q_SHIFT) - 34'(r_amean[r_dim]);
    assign nshr  = 30'(ndiff >>> Q_SHIFT);
    always_comb begin
        if (nshr > 30'sd16777215) begin
            nsat = 25'sd16777215;
        end else if (nshr < -30'sd16777216) begin
            nsat = -25'sd16777216;
        end else begin
            nsat = NORM_W'(nshr);
        end
    end

    logic start_ok, ls_on;
    assign start_ok = (r_fcnt >= FCNT_W'(r_cfg_smf));
    assign ls_on    = (r_cfg_ls != '0) && (r_fcnt >= FCNT_W'(r_cfg_ls));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_dim     <= '0;
            r_hhead   <= '0;
            r_hcnt    <= '0;
            r_fcnt    <= '0;
            r_wfill   <= '0;
            r_whead   <= '0;
            r_full    <= 1'b0;
            r_win_en  <= 1'b0;
            r_rel_req <= 1'b0;
            r_rel_all <= 1'b0;
            for (int i = 0; i < FRAME_DIM; i++) begin
                r_sum[i]   <= '0;
                r_wmean[i] <= '0;
                r_amean[i] <= '0;
            end
        end else begin
            if (hwe) begin
                r_idx <= r_idx + 1'b1;
            end else if (i_cmd.fill) begin
                r_idx <= '0;
            end
            if (i_cmd.dim_clr) begin
                r_dim <= '0;
            end else if (i_cmd.dim_inc) begin
                r_dim <= r_dim + 1'b1;
            end
            if (i_cmd.wprep) begin
                r_full     <= full;
                r_win_en   <= (win != '0);
                r_old_slot <= r_whead;
                r_new_slot <= new_slot;
                r_recip    <= RECIP_TAB[recip_idx];
                r_fcnt     <= fc_new;
                if (full) begin
                    r_whead <= whead_nxt;
                end else if (win != '0) begin
                    r_wfill <= r_wfill + 1'b1;
                end
            end
            if (i_cmd.wsum) begin
                r_sum[r_dim] <= r_sum[r_dim] + delta;
            end
            if (i_cmd.mlo) begin
                r_plo <= PLO_W'(prod);
            end
            if (i_cmd.mhi) begin
                r_phi <= prod;
            end
            if (i_cmd.wmean) begin
                r_wmean[r_dim] <= tot[TOT_W-1:RECIP_FRAC];
            end
            if (i_cmd.decide) begin
                r_hcnt <= r_hcnt + 1'b1;
                if (start_ok) begin
                    r_amean <= r_wmean;
                    if (ls_on) begin
                        r_rel_req <= (r_cfg_mf == '0) || (CW'(r_hcnt) >= CW'(r_cfg_mf));
                        r_rel_all <= 1'b1;
                    end else begin
                        r_rel_req <= (r_cfg_pu == '0) ||
                                     (CW'(r_hcnt) + 1'b1 >= CW'(r_cfg_pu));
                        r_rel_all <= !r_cfg_smooth;
                    end
                end else begin
                    r_rel_req <= 1'b0;
                end
            end
            if (i_cmd.flush) begin
                if (!start_ok) begin
                    r_amean <= r_wmean;
                end
                r_rel_req <= 1'b1;
                r_rel_all <= 1'b1;
            end
            if (i_cmd.pop) begin
                r_hhead <= head_nxt;
                r_hcnt  <= r_hcnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rld) begin
            o_norm      <= nsat;
            o_frame_end <= dim_last;
            o_run_last  <= dim_last && !rel_more;
        end
    end

endmodule

// ===== hdl/sliding_window_mean_normalizer.sv =====
// ============================================================================
// sliding_window_mean_normalizer
// Per-dimension sliding or cumulative mean removal for feature frames.
// ============================================================================
// Usage:
//   i_in carries one transaction per coefficient (command 0) or a flush
//   (command 1). Frames are FRAME_DIM coefficients closed by frame_end.
//   o_out carries normalized coefficients, FRAME_DIM per released frame,
//   out_frame_end on the last of a frame, run_last on the last result caused
//   by one input transaction.
//   i_cfg_we/i_cfg_idx/i_cfg_data write the six registers while idle.
// Sequence:
//   A coefficient without frame_end is accepted and the block stays idle. A
//   frame end passes the accept, a fill step zero-filling a short frame, the
//   window pointer update, per dimension a read, a sum update, two passes
//   through the shared 21x26 multiplier and a mean write, then the release
//   decision and check. Each released coefficient is read over the single
//   read port of the held-frame memory, loaded into the output register and
//   held until o_out.ready. A flush passes accept, flush step, check, releases.
// Reset:
//   Synchronous, active low; clears counts, pointers, sums, means and the
//   config registers. Memories hold only written entries, need no clearing.
// Stall:
//   A result stays on o_out until taken; no input is accepted meanwhile.
// ============================================================================
module sliding_window_mean_normalizer
    import swmn_pkg::*;
#(
    parameter int unsigned FRAME_DIM   = FRAME_DIM_DEF,
    parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int unsigned HOLD_FRAMES = HOLD_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    swmn_in_if.sink               i_in,
    swmn_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;   // controller -> datapath
    t_sts sts;   // datapath -> controller

    swmn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_command   (i_in.command),
        .i_frame_end (i_in.frame_end),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    // datapath holds the output register; valid comes from the controller
    swmn_dp #(
        .FRAME_DIM   (FRAME_DIM),
        .WINDOW_MAX  (WINDOW_MAX),
        .HOLD_FRAMES (HOLD_FRAMES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_coeff     (i_in.coeff_value),
        .o_norm      (o_out.norm_value),
        .o_frame_end (o_out.out_frame_end),
        .o_run_last  (o_out.run_last)
    );

endmodule

// ===== hdl/swmn_chk.sv =====
// ============================================================================
// swmn_chk
// Port-level checks bound to the normalizer top level.
// ============================================================================
module swmn_chk
    import swmn_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_in_command,
    input logic                     i_in_frame_end,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [NORM_W-1:0] i_out_norm
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_norm))
        else $error("stalled result changed");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("input taken while result pending");

    a_rst_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !i_out_valid)
        else $error("result after reset");

    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_command && !i_in_frame_end
        |=> i_in_ready && !i_out_valid)
        else $error("mid-frame coefficient did not return to idle");

endmodule

bind sliding_window_mean_normalizer swmn_chk u_swmn_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_command   (i_in.command),
    .i_in_frame_end (i_in.frame_end),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_norm     (o_out.norm_value)
);
